// ===== sv/sws_pkg.sv =====
package sws_pkg;

  // Payload buffer geometry
  localparam int PAYLOAD_DEPTH = 64;
  localparam int PTR_W   = $clog2(PAYLOAD_DEPTH + 1);
  localparam int PADDR_W = (PAYLOAD_DEPTH > 1) ? $clog2(PAYLOAD_DEPTH) : 1;
  localparam int FIDX_W  = $clog2(PAYLOAD_DEPTH + 6);

  // Frame layout: byte positions of the header
  localparam int IDX_START  = 0;
  localparam int IDX_TYPE   = 1;
  localparam int IDX_SEQ    = 2;
  localparam int IDX_LEN_HI = 3;
  localparam int IDX_LEN_LO = 4;
  localparam int HDR_LEN    = 5;

  localparam logic [7:0] FRAME_START = 8'hAA;
  localparam logic [7:0] CRC_POLY    = 8'h07;
  localparam logic [7:0] CODE_ACK    = 8'h06;

  // Item modes
  localparam logic [2:0] MODE_LOAD  = 3'd0;
  localparam logic [2:0] MODE_SEND  = 3'd1;
  localparam logic [2:0] MODE_SLOT  = 3'd2;
  localparam logic [2:0] MODE_REPLY = 3'd3;
  localparam logic [2:0] MODE_TICK  = 3'd4;

  // Status codes
  localparam logic [2:0] ST_NONE      = 3'd0;
  localparam logic [2:0] ST_DELIVERED = 3'd1;
  localparam logic [2:0] ST_EXHAUSTED = 3'd2;
  localparam logic [2:0] ST_BAD_LEN   = 3'd3;
  localparam logic [2:0] ST_REFUSED   = 3'd4;

  // Configuration register indexes and reset values
  localparam logic [1:0] CFG_RESPONSE_TIMEOUT = 2'd0;
  localparam logic [1:0] CFG_RETRY_GAP        = 2'd1;
  localparam logic [1:0] CFG_MAX_ATTEMPTS     = 2'd2;

  localparam logic [15:0] RST_RESPONSE_TIMEOUT = 16'd500;
  localparam logic [15:0] RST_RETRY_GAP        = 16'd200;
  localparam logic [3:0]  RST_MAX_ATTEMPTS     = 4'd5;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_SEND,
    PH_REPLY,
    PH_GAP
  } phase_t;

  typedef struct packed {
    logic [2:0]  mode;
    logic [7:0]  data_byte;
    logic [7:0]  frame_type;
    logic [15:0] frame_length;
  } item_t;

  typedef struct packed {
    logic       tx_valid;
    logic [7:0] tx_byte;
    logic       done_res;
    logic [2:0] status;
    logic [3:0] attempt_number;
    logic [7:0] sequence_out;
  } result_t;

  typedef struct packed {
    logic [15:0] response_timeout;
    logic [15:0] retry_gap;
    logic [3:0]  max_attempts;
  } cfg_t;

  typedef struct packed {
    logic               en;
    logic [PADDR_W-1:0] addr;
    logic [7:0]         data;
  } mem_wr_t;

  // CRC-8, one byte per call
  function automatic logic [7:0] crc_add(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int k = 0; k < 8; k++) begin
      c = c[7] ? ((c << 1) ^ CRC_POLY) : (c << 1);
    end
    return c;
  endfunction

endpackage

// ===== sv/sws_in_if.sv =====
interface sws_in_if;
  import sws_pkg::*;

  logic  valid;
  logic  ready;
  item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== sv/sws_out_if.sv =====
interface sws_out_if;
  import sws_pkg::*;

  logic    valid;
  logic    ready;
  result_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== sv/sws_payload_ram.sv =====
module sws_payload_ram (
  input  logic                        clk,
  input  sws_pkg::mem_wr_t            wr,
  input  logic                        rd_en,
  input  logic [sws_pkg::PADDR_W-1:0] rd_addr,
  output logic [7:0]                  rd_data
);
  import sws_pkg::*;

  logic [7:0] mem [PAYLOAD_DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end
endmodule

// ===== sv/sws_engine.sv =====
module sws_engine (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        go,
  input  sws_pkg::item_t              item,
  input  sws_pkg::cfg_t               cfg,
  input  logic [7:0]                  rd_data,
  output logic [sws_pkg::PADDR_W-1:0] rd_addr,
  output sws_pkg::mem_wr_t            wr,
  output sws_pkg::result_t            res
);
  import sws_pkg::*;

  phase_t             phase_r, phase_nxt;
  logic [7:0]         seq_r, seq_nxt;
  logic [3:0]         ac_r, ac_nxt, ac_pre;
  logic [FIDX_W-1:0]  fi_r, fi_nxt;
  logic [7:0]         crc_r, crc_nxt;
  logic [15:0]        wt_r, wt_nxt;
  logic               rc_r, rc_nxt;
  logic [7:0]         rfirst_r, rfirst_nxt;
  logic [PTR_W-1:0]   lp_r, lp_nxt;
  logic [7:0]         htype_r, htype_nxt;
  logic [PTR_W-1:0]   hlen_r, hlen_nxt;

  logic [3:0]         maxa;
  logic [FIDX_W-1:0]  end_idx;
  logic [15:0]        hlen16;
  logic [16:0]        wt_inc;
  logic [FIDX_W-1:0]  pay_idx;
  logic               fail;
  logic               done;
  logic [2:0]         st;
  logic               txv;
  logic [7:0]         txb;

  assign maxa    = (cfg.max_attempts == 4'd0) ? 4'd1 : cfg.max_attempts;
  assign end_idx = FIDX_W'(HDR_LEN) + FIDX_W'(hlen_r);
  assign hlen16  = 16'(hlen_r);
  assign wt_inc  = {1'b0, wt_r} + 17'd1;

  // Prefetch address: payload byte for the frame index the next item will see
  assign pay_idx = fi_nxt - FIDX_W'(HDR_LEN);
  assign rd_addr = pay_idx[PADDR_W-1:0];

  // Next state and result
  always_comb begin
    phase_nxt  = phase_r;
    seq_nxt    = seq_r;
    ac_pre     = ac_r;
    fi_nxt     = fi_r;
    crc_nxt    = crc_r;
    wt_nxt     = wt_r;
    rc_nxt     = rc_r;
    rfirst_nxt = rfirst_r;
    lp_nxt     = lp_r;
    htype_nxt  = htype_r;
    hlen_nxt   = hlen_r;
    wr         = '0;
    fail       = 1'b0;
    done       = 1'b0;
    st         = ST_NONE;
    txv        = 1'b0;
    txb        = 8'd0;

    if (go) begin
      case (item.mode)
        MODE_LOAD: begin
          if (phase_r != PH_IDLE) begin
            st = ST_REFUSED;
          end else if (lp_r < PTR_W'(PAYLOAD_DEPTH)) begin
            wr.en   = 1'b1;
            wr.addr = lp_r[PADDR_W-1:0];
            wr.data = item.data_byte;
            lp_nxt  = lp_r + PTR_W'(1);
          end
        end
        MODE_SEND: begin
          if (phase_r != PH_IDLE) begin
            st = ST_REFUSED;
          end else if (item.frame_length == 16'd0 ||
                       item.frame_length > 16'(PAYLOAD_DEPTH)) begin
            done = 1'b1;
            st   = ST_BAD_LEN;
          end else begin
            seq_nxt   = seq_r + 8'd1;
            ac_pre    = 4'd1;
            htype_nxt = item.frame_type;
            hlen_nxt  = item.frame_length[PTR_W-1:0];
            lp_nxt    = '0;
            phase_nxt = PH_SEND;
            fi_nxt    = '0;
            crc_nxt   = 8'd0;
          end
        end
        MODE_SLOT: begin
          if (phase_r == PH_SEND) begin
            txv = 1'b1;
            case (fi_r)
              FIDX_W'(IDX_START):  txb = FRAME_START;
              FIDX_W'(IDX_TYPE):   txb = htype_r;
              FIDX_W'(IDX_SEQ):    txb = seq_r;
              FIDX_W'(IDX_LEN_HI): txb = hlen16[15:8];
              FIDX_W'(IDX_LEN_LO): txb = hlen16[7:0];
              default:             txb = (fi_r < end_idx) ? rd_data : crc_r;
            endcase
            if (fi_r != FIDX_W'(IDX_START) && fi_r < end_idx) begin
              crc_nxt = crc_add(crc_r, txb);
            end
            if (fi_r >= end_idx) begin
              phase_nxt = PH_REPLY;
              wt_nxt    = 16'd0;
              rc_nxt    = 1'b0;
            end else begin
              fi_nxt = fi_r + FIDX_W'(1);
            end
          end
        end
        MODE_REPLY: begin
          if (phase_r == PH_REPLY) begin
            if (!rc_r) begin
              rfirst_nxt = item.data_byte;
              rc_nxt     = 1'b1;
              wt_nxt     = 16'd0;
            end else begin
              rc_nxt = 1'b0;
              if (rfirst_r == CODE_ACK && item.data_byte == seq_r) begin
                phase_nxt = PH_IDLE;
                done      = 1'b1;
                st        = ST_DELIVERED;
              end else begin
                fail = 1'b1;
              end
            end
          end
        end
        MODE_TICK: begin
          if (phase_r == PH_REPLY) begin
            wt_nxt = wt_inc[15:0];
            if (wt_inc >= {1'b0, cfg.response_timeout}) begin
              rc_nxt = 1'b0;
              fail   = 1'b1;
            end
          end else if (phase_r == PH_GAP) begin
            wt_nxt = wt_inc[15:0];
            if (wt_inc >= {1'b0, cfg.retry_gap}) begin
              ac_pre    = ac_r + 4'd1;
              phase_nxt = PH_SEND;
              fi_nxt    = '0;
              crc_nxt   = 8'd0;
            end
          end
        end
        default: begin
        end
      endcase

      // Failed attempt: give up, retry at once, or wait out the gap
      if (fail) begin
        if (ac_r >= maxa) begin
          phase_nxt = PH_IDLE;
          done      = 1'b1;
          st        = ST_EXHAUSTED;
        end else if (cfg.retry_gap == 16'd0) begin
          ac_pre    = ac_r + 4'd1;
          phase_nxt = PH_SEND;
          fi_nxt    = '0;
          crc_nxt   = 8'd0;
        end else begin
          phase_nxt = PH_GAP;
          wt_nxt    = 16'd0;
        end
      end
    end

    ac_nxt = (done && (st == ST_DELIVERED || st == ST_EXHAUSTED)) ? 4'd0 : ac_pre;

    res.tx_valid       = txv;
    res.tx_byte        = txb;
    res.done_res       = done;
    res.status         = st;
    res.attempt_number = (phase_nxt == PH_IDLE && !done) ? 4'd0 : ac_pre;
    res.sequence_out   = seq_nxt;
  end

  // State registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_IDLE;
      seq_r    <= 8'd0;
      ac_r     <= 4'd0;
      fi_r     <= '0;
      crc_r    <= 8'd0;
      wt_r     <= 16'd0;
      rc_r     <= 1'b0;
      rfirst_r <= 8'd0;
      lp_r     <= '0;
      htype_r  <= 8'd0;
      hlen_r   <= '0;
    end else begin
      phase_r  <= phase_nxt;
      seq_r    <= seq_nxt;
      ac_r     <= ac_nxt;
      fi_r     <= fi_nxt;
      crc_r    <= crc_nxt;
      wt_r     <= wt_nxt;
      rc_r     <= rc_nxt;
      rfirst_r <= rfirst_nxt;
      lp_r     <= lp_nxt;
      htype_r  <= htype_nxt;
      hlen_r   <= hlen_nxt;
    end
  end

  // Idle always means no attempt in flight
  a_idle_no_attempt: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_IDLE |-> ac_r == 4'd0)
    else $error("attempt count nonzero while idle");

  // A finished message leaves the block idle
  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    go && res.done_res |=> phase_r == PH_IDLE)
    else $error("message finished but phase not idle");

  // Frame index never runs past the CRC byte
  a_fi_bound: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_SEND |-> fi_r <= end_idx)
    else $error("frame index past end of frame");

  // The buffer is written only while idle
  a_load_idle: assert property (@(posedge clk) disable iff (!rst_n)
    wr.en |-> phase_r == PH_IDLE && lp_r < PTR_W'(PAYLOAD_DEPTH))
    else $error("payload write outside idle or beyond depth");
endmodule

// ===== sv/stop_and_wait_frame_sender.sv =====
// Each result is registered: the execute stage holding the transferred item feeds the output
// register, from which the result transfers once ready is high.
// Throughput: one item per cycle unless the output stalls; the payload byte for the next
// transmit slot is prefetched from the registered-read payload RAM while the current item executes.
// A stalled result register holds one result and the execute stage one more item before ready drops.
// Reset (rst_n low, synchronous): control state and sequence number clear, registers return to
// timeout 500, gap 200, attempts 5; the payload RAM is not cleared.
module stop_and_wait_frame_sender (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_wdata,
  sws_in_if.sink      in_ch,
  sws_out_if.source   out_ch
);
  import sws_pkg::*;

  cfg_t               cfg_r;
  logic               s1_v_r;
  item_t              item_r;
  logic               out_v_r;
  result_t            out_data_r;
  logic               go;
  logic               in_xfer;
  logic [PADDR_W-1:0] rd_addr;
  logic [7:0]         rd_data;
  mem_wr_t            wr;
  result_t            res;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.response_timeout <= RST_RESPONSE_TIMEOUT;
      cfg_r.retry_gap        <= RST_RETRY_GAP;
      cfg_r.max_attempts     <= RST_MAX_ATTEMPTS;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_RESPONSE_TIMEOUT: cfg_r.response_timeout <= cfg_wdata;
        CFG_RETRY_GAP:        cfg_r.retry_gap        <= cfg_wdata;
        CFG_MAX_ATTEMPTS:     cfg_r.max_attempts     <= cfg_wdata[3:0];
        default: begin
        end
      endcase
    end
  end

  // Pipeline control
  assign go          = s1_v_r && (!out_v_r || out_ch.ready);
  assign in_ch.ready = !s1_v_r || go;
  assign in_xfer     = in_ch.valid && in_ch.ready;

  // Execute-stage item register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (in_ch.ready) begin
      s1_v_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      item_r <= in_ch.data;
    end
  end

  sws_payload_ram u_ram (
    .clk     (clk),
    .wr      (wr),
    .rd_en   (in_xfer),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  sws_engine u_engine (
    .clk     (clk),
    .rst_n   (rst_n),
    .go      (go),
    .item    (item_r),
    .cfg     (cfg_r),
    .rd_data (rd_data),
    .rd_addr (rd_addr),
    .wr      (wr),
    .res     (res)
  );

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (go) begin
      out_v_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      out_data_r <= res;
    end
  end

  assign out_ch.valid = out_v_r;
  assign out_ch.data  = out_data_r;

  // An executed item always lands in the output register
  a_go_fills_out: assert property (@(posedge clk) disable iff (!rst_n)
    go |=> out_v_r)
    else $error("executed item produced no result");

  // A stalled execute stage keeps its item
  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    s1_v_r && !go |=> s1_v_r && $stable(item_r))
    else $error("stalled item lost");

  // A waiting result is not overwritten
  a_out_holds: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r && !out_ch.ready |=> out_v_r && $stable(out_data_r))
    else $error("pending result overwritten");
endmodule

// ===== dv/tb_top.sv =====
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import sws_pkg::*;

  // Codes the package does not name
  localparam logic [7:0] NACK_CODE      = 8'h15;
  localparam logic [2:0] MODE_UNUSED_LO = 3'd5;
  localparam logic [2:0] MODE_UNUSED_HI = 3'd7;

  // One queued input item together with the result it must produce
  typedef struct {
    item_t   item;
    result_t want;
  } frame_step_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = '0;
  logic [15:0] cfg_wdata = '0;

  sws_in_if  in_ch ();
  sws_out_if out_ch ();

  stop_and_wait_frame_sender DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Sender-side shadow state, advanced as items are queued
  phase_t      ph = PH_IDLE;
  logic [7:0]  seq_num = '0;
  logic [3:0]  attempt_cnt = '0;
  int unsigned frame_idx = 0;
  int unsigned wait_cnt = 0;
  int unsigned reply_cnt = 0;
  int unsigned load_ptr = 0;
  int unsigned bytes_written = 0;
  logic [7:0]  crc_acc = '0;
  logic [7:0]  reply_head = '0;
  logic [7:0]  hold_type = '0;
  logic [15:0] hold_len = '0;
  logic [7:0]  payload_mem [PAYLOAD_DEPTH];
  logic [15:0] cfg_timeout = RST_RESPONSE_TIMEOUT;
  logic [15:0] cfg_gap = RST_RETRY_GAP;
  logic [3:0]  cfg_attempts = RST_MAX_ATTEMPTS;

  frame_step_t queued_items [$];
  result_t     awaited_results [$];
  frame_step_t live_item;
  result_t     got;

  int unsigned send_idle_pct = 18;
  int unsigned recv_stall_pct = 78;
  int unsigned items_queued = 0;
  int unsigned items_taken = 0;
  int unsigned items_made = 0;
  int unsigned results_seen = 0;
  int unsigned fail_count = 0;
  int unsigned delivered_total = 0;
  int unsigned exhausted_total = 0;
  int unsigned bad_len_total = 0;
  int unsigned settings_count = 0;

  // CRC-8, poly 0x07, fed one bit at a time MSB first
  function automatic logic [7:0] crc8_next(logic [7:0] acc, logic [7:0] b);
    logic [7:0] r;
    logic       fb;
    r = acc;
    for (int n = 7; n >= 0; n--) begin
      fb = r[7] ^ b[n];
      r = {r[6:0], 1'b0} ^ (fb ? CRC_POLY : 8'h00);
    end
    return r;
  endfunction

  function automatic void begin_attempt();
    ph = PH_SEND;
    frame_idx = 0;
    crc_acc = '0;
  endfunction

  // Failed attempt: give up, back off, or resend at once when the gap is zero
  function automatic logic [2:0] attempt_failed();
    if (attempt_cnt >= cfg_attempts) begin
      ph = PH_IDLE;
      return ST_EXHAUSTED;
    end
    if (cfg_gap == 0) begin
      attempt_cnt = attempt_cnt + 1'b1;
      begin_attempt();
    end else begin
      ph = PH_GAP;
      wait_cnt = 0;
    end
    return ST_NONE;
  endfunction

  function automatic result_t sender_next_result(item_t it);
    result_t     r;
    logic [3:0]  att;
    logic [7:0]  b;
    int unsigned idx;
    r = '0;
    r.tx_byte = '0;
    case (it.mode)
      MODE_LOAD: begin
        if (ph != PH_IDLE) begin
          r.status = ST_REFUSED;
        end else if (load_ptr < PAYLOAD_DEPTH) begin
          payload_mem[load_ptr] = it.data_byte;
          load_ptr++;
          if (load_ptr > bytes_written) bytes_written = load_ptr;
        end
      end
      MODE_SEND: begin
        if (ph != PH_IDLE) begin
          r.status = ST_REFUSED;
        end else if (it.frame_length == 0 || it.frame_length > PAYLOAD_DEPTH) begin
          r.done_res = 1'b1;
          r.status = ST_BAD_LEN;
          bad_len_total++;
        end else begin
          seq_num = seq_num + 1'b1;
          attempt_cnt = 4'd1;
          hold_type = it.frame_type;
          hold_len = it.frame_length;
          load_ptr = 0;
          begin_attempt();
        end
      end
      MODE_SLOT: begin
        if (ph == PH_SEND) begin
          idx = frame_idx;
          r.tx_valid = 1'b1;
          if (idx == IDX_START) b = FRAME_START;
          else if (idx == IDX_TYPE) b = hold_type;
          else if (idx == IDX_SEQ) b = seq_num;
          else if (idx == IDX_LEN_HI) b = hold_len[15:8];
          else if (idx == IDX_LEN_LO) b = hold_len[7:0];
          else if (idx < HDR_LEN + hold_len) b = payload_mem[idx - HDR_LEN];
          else b = crc_acc;
          r.tx_byte = b;
          if (idx >= IDX_TYPE && idx < HDR_LEN + hold_len) crc_acc = crc8_next(crc_acc, b);
          if (idx >= HDR_LEN + hold_len) begin
            ph = PH_REPLY;
            wait_cnt = 0;
            reply_cnt = 0;
          end else begin
            frame_idx = idx + 1;
          end
        end
      end
      MODE_REPLY: begin
        if (ph == PH_REPLY) begin
          if (reply_cnt == 0) begin
            reply_head = it.data_byte;
            reply_cnt = 1;
            wait_cnt = 0;
          end else begin
            reply_cnt = 0;
            if (reply_head == CODE_ACK && it.data_byte == seq_num) begin
              ph = PH_IDLE;
              r.done_res = 1'b1;
              r.status = ST_DELIVERED;
            end else begin
              r.status = attempt_failed();
              r.done_res = (r.status != ST_NONE);
            end
          end
        end
      end
      MODE_TICK: begin
        if (ph == PH_REPLY) begin
          wait_cnt++;
          if (wait_cnt >= cfg_timeout) begin
            reply_cnt = 0;
            r.status = attempt_failed();
            r.done_res = (r.status != ST_NONE);
          end
        end else if (ph == PH_GAP) begin
          wait_cnt++;
          if (wait_cnt >= cfg_gap) begin
            attempt_cnt = attempt_cnt + 1'b1;
            begin_attempt();
          end
        end
      end
      default: ;
    endcase
    att = attempt_cnt;
    // a finished message reports the attempt that ended it, then clears the count
    if (r.done_res && (r.status == ST_DELIVERED || r.status == ST_EXHAUSTED)) begin
      if (r.status == ST_DELIVERED) delivered_total++;
      else exhausted_total++;
      att = attempt_cnt;
      attempt_cnt = '0;
    end
    if (ph == PH_IDLE && !r.done_res) att = '0;
    r.attempt_number = att;
    r.sequence_out = seq_num;
    return r;
  endfunction

  task automatic push_item(logic [2:0] mode, logic [7:0] db, logic [7:0] ft,
                           logic [15:0] fl, bit counted);
    frame_step_t s;
    s.item.mode = mode;
    s.item.data_byte = db;
    s.item.frame_type = ft;
    s.item.frame_length = fl;
    s.want = sender_next_result(s.item);
    queued_items.push_back(s);
    items_queued++;
    if (counted) items_made++;
  endtask

  // Occasional stray item of any mode; never a send that would read unloaded payload
  task automatic maybe_noise();
    logic [2:0]  m;
    logic [15:0] fl;
    if ($urandom_range(11) != 0) return;
    m = 3'($urandom_range(7));
    fl = 16'($urandom_range(65535));
    if (m == MODE_SEND && ph == PH_IDLE && fl != 0 && fl <= PAYLOAD_DEPTH && fl > bytes_written)
      fl = 16'd0;
    push_item(m, 8'($urandom_range(255)), 8'($urandom_range(255)), fl, 1'b0);
  endtask

  // One message: optional loads, send, then follow the frame through slots, replies and ticks
  task automatic gen_message(bit fail_first);
    int unsigned k;
    int unsigned len;
    int unsigned cap;
    int unsigned pick;
    bit          forced;
    forced = fail_first;
    if (bytes_written == 0 || $urandom_range(2) != 0) begin
      if ($urandom_range(3) == 0) k = $urandom_range(1) ? $urandom_range(70, 60) : $urandom_range(64);
      else k = $urandom_range(6);
      if (bytes_written == 0 && k == 0) k = 1;
      repeat (k) begin
        push_item(MODE_LOAD, 8'($urandom_range(255)), 8'($urandom_range(255)),
                  16'($urandom_range(65535)), 1'b1);
        maybe_noise();
      end
    end
    if ($urandom_range(9) == 0)
      push_item(MODE_SEND, 8'($urandom_range(255)), 8'($urandom_range(255)),
                $urandom_range(1) ? 16'd0 : 16'($urandom_range(65535, PAYLOAD_DEPTH + 1)), 1'b1);
    cap = (bytes_written < 8) ? bytes_written : 8;
    if (bytes_written == 0) len = 0;
    else if ($urandom_range(7) == 0) len = $urandom_range(bytes_written, 1);
    else len = $urandom_range(cap, 1);
    push_item(MODE_SEND, 8'($urandom_range(255)), 8'($urandom_range(255)), 16'(len), 1'b1);
    while (ph != PH_IDLE) begin
      case (ph)
        PH_SEND: push_item(MODE_SLOT, 8'($urandom_range(255)), 8'($urandom_range(255)),
                           16'($urandom_range(65535)), 1'b1);
        PH_GAP: push_item(MODE_TICK, 8'($urandom_range(255)), 8'($urandom_range(255)),
                          16'($urandom_range(65535)), 1'b1);
        PH_REPLY: begin
          if (reply_cnt != 0) begin
            push_item(MODE_REPLY, seq_num, 8'($urandom_range(255)),
                      16'($urandom_range(65535)), 1'b1);
          end else begin
            pick = $urandom_range(9);
            if (forced) begin
              pick = 5;
              forced = 1'b0;
            end else begin
              // long waits are only worth it now and then
              if (pick >= 8 && (cfg_timeout > 1000 || (cfg_timeout > 64 && $urandom_range(19) != 0)))
                pick = 0;
              if (pick >= 5 && cfg_gap > 1000) pick = 0;
            end
            case (pick)
              5: begin
                push_item(MODE_REPLY, NACK_CODE, 8'($urandom_range(255)),
                          16'($urandom_range(65535)), 1'b1);
                push_item(MODE_REPLY, 8'($urandom_range(255)), 8'($urandom_range(255)),
                          16'($urandom_range(65535)), 1'b1);
              end
              6: begin
                push_item(MODE_REPLY, CODE_ACK, 8'($urandom_range(255)),
                          16'($urandom_range(65535)), 1'b1);
                push_item(MODE_REPLY, seq_num ^ 8'($urandom_range(255, 1)),
                          8'($urandom_range(255)), 16'($urandom_range(65535)), 1'b1);
              end
              7: begin
                k = $urandom_range(255);
                if (k == CODE_ACK) k = k ^ 8'h80;
                push_item(MODE_REPLY, 8'(k), 8'($urandom_range(255)),
                          16'($urandom_range(65535)), 1'b1);
                push_item(MODE_REPLY, 8'($urandom_range(255)), 8'($urandom_range(255)),
                          16'($urandom_range(65535)), 1'b1);
              end
              8, 9: begin
                if (pick == 9)
                  push_item(MODE_REPLY, 8'($urandom_range(255)), 8'($urandom_range(255)),
                            16'($urandom_range(65535)), 1'b1);
                while (ph == PH_REPLY)
                  push_item(MODE_TICK, 8'($urandom_range(255)), 8'($urandom_range(255)),
                            16'($urandom_range(65535)), 1'b1);
              end
              default: begin
                push_item(MODE_REPLY, CODE_ACK, 8'($urandom_range(255)),
                          16'($urandom_range(65535)), 1'b1);
                push_item(MODE_REPLY, seq_num, 8'($urandom_range(255)),
                          16'($urandom_range(65535)), 1'b1);
              end
            endcase
          end
        end
        default: ;
      endcase
      maybe_noise();
    end
  endtask

  task automatic gen_until(int unsigned n);
    int unsigned target;
    target = items_made + n;
    while (items_made < target) gen_message(1'b0);
  endtask

  // Wait until every queued item has gone in and every result has come back
  task automatic drain();
    while (items_taken != items_queued || awaited_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [15:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    case (idx)
      CFG_RESPONSE_TIMEOUT: cfg_timeout = val;
      CFG_RETRY_GAP:        cfg_gap = val;
      CFG_MAX_ATTEMPTS:     cfg_attempts = (val[3:0] == 0) ? 4'd1 : val[3:0];
      default: ;
    endcase
  endtask

  task automatic apply_settings(logic [15:0] tmo, logic [15:0] gap, logic [3:0] att);
    logic [11:0] junk;
    drain();
    junk = 12'($urandom_range(4095));
    write_reg(CFG_RESPONSE_TIMEOUT, tmo);
    write_reg(CFG_RETRY_GAP, gap);
    write_reg(CFG_MAX_ATTEMPTS, {junk, att});
    @(posedge clk);
    cfg_we <= 1'b0;
    settings_count++;
  endtask

  // Short hand-picked sequence at reset defaults
  task automatic directed_items();
    // no-ops while idle, unknown modes with all fields at their extremes
    push_item(MODE_TICK, 8'hFF, 8'hFF, 16'hFFFF, 1'b1);
    push_item(MODE_SLOT, 8'h00, 8'h00, 16'h0000, 1'b1);
    push_item(MODE_REPLY, CODE_ACK, 8'h00, 16'h0001, 1'b1);
    push_item(MODE_UNUSED_LO, 8'h00, 8'h00, 16'h0000, 1'b1);
    push_item(MODE_UNUSED_HI, 8'hFF, 8'hFF, 16'hFFFF, 1'b1);
    // rejected lengths
    push_item(MODE_SEND, 8'h00, 8'h11, 16'd0, 1'b1);
    push_item(MODE_SEND, 8'h00, 8'h22, 16'hFFFF, 1'b1);
    push_item(MODE_SEND, 8'h00, 8'h33, 16'(PAYLOAD_DEPTH + 1), 1'b1);
    // three-byte message, refused commands while busy, clean ACK
    push_item(MODE_LOAD, 8'h00, 8'h00, 16'h0000, 1'b1);
    push_item(MODE_LOAD, 8'hFF, 8'h00, 16'h0000, 1'b1);
    push_item(MODE_LOAD, 8'h5A, 8'h00, 16'h0000, 1'b1);
    push_item(MODE_SEND, 8'h00, 8'hFF, 16'd3, 1'b1);
    push_item(MODE_SEND, 8'h00, 8'h01, 16'd1, 1'b1);
    push_item(MODE_LOAD, 8'hC3, 8'h00, 16'h0000, 1'b1);
    repeat (HDR_LEN + 3 + 1) push_item(MODE_SLOT, 8'h00, 8'h00, 16'h0000, 1'b1);
    push_item(MODE_REPLY, CODE_ACK, 8'h00, 16'h0000, 1'b1);
    push_item(MODE_REPLY, seq_num, 8'h00, 16'h0000, 1'b1);
  endtask

  // Input driver: a new item is presented once the previous one has transferred
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else if (!in_ch.valid || in_ch.ready) begin
      if (in_ch.valid) begin
        awaited_results.push_back(live_item.want);
        items_taken++;
      end
      if (queued_items.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        live_item = queued_items.pop_front();
        in_ch.data <= live_item.item;
        in_ch.valid <= 1'b1;
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // Result monitor with random back-pressure
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        results_seen++;
        got = out_ch.data;
        if (awaited_results.size() == 0) begin
          $error("result transfer with nothing expected: %h", got);
          fail_count++;
        end else begin
          if (got.tx_valid !== awaited_results[0].tx_valid) begin
            $error("tx_valid: expected %0d, got %0d", awaited_results[0].tx_valid, got.tx_valid);
            fail_count++;
          end
          if (got.tx_byte !== awaited_results[0].tx_byte) begin
            $error("tx_byte: expected %h, got %h", awaited_results[0].tx_byte, got.tx_byte);
            fail_count++;
          end
          if (got.done_res !== awaited_results[0].done_res) begin
            $error("done_res: expected %0d, got %0d", awaited_results[0].done_res, got.done_res);
            fail_count++;
          end
          if (got.status !== awaited_results[0].status) begin
            $error("status: expected %0d, got %0d", awaited_results[0].status, got.status);
            fail_count++;
          end
          if (got.attempt_number !== awaited_results[0].attempt_number) begin
            $error("attempt_number: expected %0d, got %0d",
                   awaited_results[0].attempt_number, got.attempt_number);
            fail_count++;
          end
          if (got.sequence_out !== awaited_results[0].sequence_out) begin
            $error("sequence_out: expected %h, got %h",
                   awaited_results[0].sequence_out, got.sequence_out);
            fail_count++;
          end
          void'(awaited_results.pop_front());
        end
      end
      out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Stimulus sequence
  initial begin
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    out_ch.ready = 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // sender mostly busy, receiver mostly stalled
    send_idle_pct = 18;
    recv_stall_pct = 78;
    directed_items();
    gen_until(60);
    apply_settings(16'($urandom_range(12, 1)), 16'($urandom_range(6)),
                   4'($urandom_range(6, 2)));
    gen_until(400);
    drain();
    gen_until(300);

    // roles swapped; zero timeout, zero gap and zero attempts first
    send_idle_pct = 78;
    recv_stall_pct = 18;
    apply_settings(16'd0, 16'd0, 4'd0);
    gen_until(150);
    apply_settings(16'd1, 16'd1, 4'd15);
    gen_until(200);
    apply_settings(16'($urandom_range(20, 1)), 16'($urandom_range(10)),
                   4'($urandom_range(15, 1)));
    gen_until(400);

    // no idling; largest timeout with a short gap, one forced retry
    send_idle_pct = 0;
    recv_stall_pct = 0;
    apply_settings(16'hFFFF, 16'd40, 4'd15);
    gen_message(1'b1);
    gen_until(100);
    apply_settings(16'($urandom_range(20, 1)), 16'($urandom_range(10)),
                   4'($urandom_range(15, 1)));
    gen_until(500);

    drain();
    repeat (8) @(posedge clk);
    $display("Run covered %0d input transfers and %0d checked results over %0d register settings.",
             items_taken, results_seen, settings_count + 1);
    $display("Messages: %0d delivered, %0d gave up, %0d rejected for length; %0d mismatches.",
             delivered_total, exhausted_total, bad_len_total, fail_count);
    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #10000000;
    $display("timeout: %0d of %0d items in, %0d results pending",
             items_taken, items_queued, awaited_results.size());
    $display("simulation failed");
    $finish;
  end

endmodule
